// ===== rtl/core/pbfl_pkg.sv =====
// shared types and constants for the protobuf field locator
package pbfl_pkg;

    // message limits and field widths
    localparam int unsigned MSG_LEN_MAX = 4096;
    localparam int unsigned POS_W       = 13;
    localparam int unsigned OFS_W       = 12;
    localparam int unsigned LEN_W       = 13;
    localparam int unsigned ACC_W       = 35;
    localparam int unsigned FIELD_W     = 32;
    localparam int unsigned CFG_W       = 32;
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 56;

    // varint byte count that signals an over-long varint
    localparam logic [3:0] VCNT_LIMIT = 4'd10;

    // parse phases
    localparam logic [1:0] PH_TAG    = 2'd0;
    localparam logic [1:0] PH_VALUE  = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    // wire types
    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_FIX64  = 3'd1;
    localparam logic [2:0] WT_LENDEL = 3'd2;
    localparam logic [2:0] WT_FIX32  = 3'd5;

    // error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_VARINT = 3'd1;
    localparam logic [2:0] ERR_WIRE   = 3'd2;
    localparam logic [2:0] ERR_TRUNC  = 3'd3;
    localparam logic [2:0] ERR_LONG   = 3'd4;

    // configuration register indexes
    localparam logic CFG_FIRST  = 1'b0;
    localparam logic CFG_SECOND = 1'b1;

    // one capture record
    typedef struct packed {
        logic             found;
        logic [OFS_W-1:0] offset;
        logic [LEN_W-1:0] length;
    } pbfl_capture_t;

    // one result item
    typedef struct packed {
        logic          decode_ok;
        logic [2:0]    error_kind;
        pbfl_capture_t first;
        pbfl_capture_t second;
    } pbfl_result_t;

endpackage

// ===== rtl/core/protobuf_field_locator_unit.sv =====
// Protobuf field locator: walks a message one byte per cycle, reports once per message.
// Throughput: one byte transfer per cycle, sustained, set by the single-pass walker step;
// a last byte waits only while the result register is full and not being taken.
// The result is registered: the last byte moves from the input register through the
// walker step into the result register, which presents it.
// Reset: synchronous, active low; clears message state and sets the capture fields to 2 and 3.
module protobuf_field_locator_unit
    import pbfl_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // data_byte
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // decode_ok, error_kind, first_found, first_offset, first_length,
    // second_found, second_offset, second_length
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         byte_last;
    logic         out_free;
    logic         step;
    logic         res_valid;
    pbfl_result_t res;
    pbfl_result_t held;

    // a last byte waits for room in the result register
    assign step = byte_valid && (!byte_last || out_free);

    pbfl_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_last  (byte_last)
    );

    pbfl_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .byte_data   (byte_data),
        .byte_last   (byte_last),
        .res_valid   (res_valid),
        .res         (res)
    );

    pbfl_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .held      (held)
    );

    // pack result fields from the lowest bit up
    assign m_tdata = {held.second.length, held.second.offset, held.second.found,
                      held.first.length,  held.first.offset,  held.first.found,
                      held.error_kind, held.decode_ok};

endmodule

// ===== rtl/core/pbfl_in_reg.sv =====
// input register holding one message byte ahead of the walker
module pbfl_in_reg
    import pbfl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    input  logic                  s_tlast,
    input  logic                  take,
    output logic                  byte_valid,
    output logic [7:0]            byte_data,
    output logic                  byte_last
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;
    logic       last_reg;

    // free when empty or when the held byte is consumed this cycle
    assign s_tready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata[7:0];
            last_reg <= s_tlast;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
    assign byte_last  = last_reg;

endmodule

// ===== rtl/core/pbfl_walker.sv =====
// wire-format walker: varint decode, payload skip, capture and error tracking
module pbfl_walker
    import pbfl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             step,
    input  logic [7:0]       byte_data,
    input  logic             byte_last,
    output logic             res_valid,
    output pbfl_result_t     res
);

    logic [CFG_W-1:0]   first_field_reg;
    logic [CFG_W-1:0]   second_field_reg;

    logic [1:0]         phase_reg,  phase_next;
    logic [ACC_W-1:0]   acc_reg,    acc_next;
    logic               hi_nz_reg,  hi_nz_next;
    logic [3:0]         vcnt_reg,   vcnt_next;
    logic               match_first_reg,  match_first_next;
    logic               match_second_reg, match_second_next;
    logic [LEN_W-1:0]   skip_reg,   skip_next;
    logic [POS_W-1:0]   pos_reg,    pos_next;
    logic [2:0]         err_reg,    err_next;
    pbfl_capture_t      cap0_reg,   cap0_next;
    pbfl_capture_t      cap1_reg,   cap1_next;

    logic [ACC_W-1:0]   acc_or;
    logic               hi_or;
    logic [3:0]         vcnt_inc;
    logic [LEN_W-1:0]   skip_dec;
    logic [POS_W-1:0]   pos_inc;
    logic [POS_W-1:0]   room;
    logic [2:0]         fin_err;

    // position after this byte and the room left behind it
    assign vcnt_inc  = vcnt_reg + 4'd1;
    assign pos_inc   = pos_reg + POS_W'(1);
    assign room      = POS_W'(MSG_LEN_MAX) - pos_inc;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_field_reg  <= CFG_W'(2);
            second_field_reg <= CFG_W'(3);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_FIRST:  first_field_reg  <= cfg_wr_data;
                CFG_SECOND: second_field_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // next state for one byte
    always_comb begin
        phase_next        = phase_reg;
        acc_next          = acc_reg;
        hi_nz_next        = hi_nz_reg;
        vcnt_next         = vcnt_reg;
        match_first_next  = match_first_reg;
        match_second_next = match_second_reg;
        skip_next         = skip_reg;
        pos_next          = pos_reg;
        err_next          = err_reg;
        cap0_next         = cap0_reg;
        cap1_next         = cap1_reg;
        acc_or            = acc_reg;
        hi_or             = hi_nz_reg;
        skip_dec          = skip_reg;
        fin_err           = ERR_NONE;
        res_valid         = 1'b0;
        res               = '0;

        if (step) begin
            if (pos_reg >= POS_W'(MSG_LEN_MAX)) begin
                // byte beyond the size limit
                if (err_reg == ERR_NONE) begin
                    err_next = ERR_LONG;
                end
            end else begin
                pos_next = pos_inc;
                if (err_reg == ERR_NONE) begin
                    if (phase_reg == PH_SKIP) begin
                        // payload byte being skipped
                        if (skip_reg != '0) begin
                            skip_dec = skip_reg - LEN_W'(1);
                        end
                        skip_next = skip_dec;
                        if (skip_dec == '0) begin
                            phase_next = PH_TAG;
                        end
                    end else begin
                        // fold the byte into the varint
                        case (vcnt_reg)
                            4'd0: acc_or[6:0]   = acc_reg[6:0]   | byte_data[6:0];
                            4'd1: acc_or[13:7]  = acc_reg[13:7]  | byte_data[6:0];
                            4'd2: acc_or[20:14] = acc_reg[20:14] | byte_data[6:0];
                            4'd3: acc_or[27:21] = acc_reg[27:21] | byte_data[6:0];
                            4'd4: acc_or[34:28] = acc_reg[34:28] | byte_data[6:0];
                            4'd5, 4'd6, 4'd7, 4'd8: begin
                                if (byte_data[6:0] != 7'd0) begin
                                    hi_or = 1'b1;
                                end
                            end
                            4'd9: begin
                                if (byte_data[0]) begin
                                    hi_or = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                        acc_next   = acc_or;
                        hi_nz_next = hi_or;
                        if (byte_data[7]) begin
                            vcnt_next = vcnt_inc;
                            if (vcnt_inc >= VCNT_LIMIT) begin
                                err_next = ERR_VARINT;
                            end
                        end else begin
                            // varint complete
                            acc_next   = '0;
                            hi_nz_next = 1'b0;
                            vcnt_next  = 4'd0;
                            case (phase_reg)
                                PH_TAG: begin
                                    match_first_next  = (acc_or[ACC_W-1:3] == first_field_reg);
                                    match_second_next = (acc_or[ACC_W-1:3] == second_field_reg);
                                    case (acc_or[2:0])
                                        WT_VARINT: phase_next = PH_VALUE;
                                        WT_FIX64: begin
                                            phase_next = PH_SKIP;
                                            skip_next  = LEN_W'(8);
                                        end
                                        WT_LENDEL: phase_next = PH_LENGTH;
                                        WT_FIX32: begin
                                            phase_next = PH_SKIP;
                                            skip_next  = LEN_W'(4);
                                        end
                                        default: err_next = ERR_WIRE;
                                    endcase
                                end
                                PH_LENGTH: begin
                                    if (hi_or || (acc_or > ACC_W'(room))) begin
                                        err_next = ERR_TRUNC;
                                    end else begin
                                        if (match_first_reg) begin
                                            cap0_next.found  = 1'b1;
                                            cap0_next.offset = pos_inc[OFS_W-1:0];
                                            cap0_next.length = acc_or[LEN_W-1:0];
                                        end else if (match_second_reg) begin
                                            cap1_next.found  = 1'b1;
                                            cap1_next.offset = pos_inc[OFS_W-1:0];
                                            cap1_next.length = acc_or[LEN_W-1:0];
                                        end
                                        if (acc_or[LEN_W-1:0] == '0) begin
                                            phase_next = PH_TAG;
                                        end else begin
                                            phase_next = PH_SKIP;
                                            skip_next  = acc_or[LEN_W-1:0];
                                        end
                                    end
                                end
                                default: phase_next = PH_TAG;
                            endcase
                        end
                    end
                end
            end

            // end of message: report and start afresh
            if (byte_last) begin
                fin_err = err_next;
                if (fin_err == ERR_NONE && (phase_next != PH_TAG || vcnt_next != 4'd0)) begin
                    fin_err = ERR_TRUNC;
                end
                res_valid      = 1'b1;
                res.decode_ok  = (fin_err == ERR_NONE);
                res.error_kind = fin_err;
                res.first      = cap0_next;
                res.second     = cap1_next;

                phase_next        = PH_TAG;
                acc_next          = '0;
                hi_nz_next        = 1'b0;
                vcnt_next         = 4'd0;
                match_first_next  = 1'b0;
                match_second_next = 1'b0;
                skip_next         = '0;
                pos_next          = '0;
                err_next          = ERR_NONE;
                cap0_next         = '0;
                cap1_next         = '0;
            end
        end
    end

    // message state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TAG;
            acc_reg          <= '0;
            hi_nz_reg        <= 1'b0;
            vcnt_reg         <= 4'd0;
            match_first_reg  <= 1'b0;
            match_second_reg <= 1'b0;
            skip_reg         <= '0;
            pos_reg          <= '0;
            err_reg          <= ERR_NONE;
            cap0_reg         <= '0;
            cap1_reg         <= '0;
        end else begin
            phase_reg        <= phase_next;
            acc_reg          <= acc_next;
            hi_nz_reg        <= hi_nz_next;
            vcnt_reg         <= vcnt_next;
            match_first_reg  <= match_first_next;
            match_second_reg <= match_second_next;
            skip_reg         <= skip_next;
            pos_reg          <= pos_next;
            err_reg          <= err_next;
            cap0_reg         <= cap0_next;
            cap1_reg         <= cap1_next;
        end
    end

endmodule

// ===== rtl/core/pbfl_out_reg.sv =====
// result register on the master side
module pbfl_out_reg
    import pbfl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         res_valid,
    input  pbfl_result_t res,
    output logic         out_free,
    output logic         m_tvalid,
    input  logic         m_tready,
    output pbfl_result_t held
);

    logic         valid_reg;
    logic         valid_next;
    pbfl_result_t res_reg;

    // can load when empty or when the held result is taken this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (res_valid) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign held     = res_reg;

endmodule

// ===== rtl/core/pbfl_checker.sv =====
// port-level checks for the protobuf field locator, bound to the top level
module pbfl_checker
    import pbfl_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // ok flag agrees with the error code
    a_ok_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[3:1] == ERR_NONE)))
        else $error("decode_ok disagrees with error_kind");

    // error code within its defined set
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:1] <= ERR_LONG))
        else $error("undefined error code");

    // captures not found report zero location
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[4] || m_tdata[29:5] == '0) &&
                      (m_tdata[30] || m_tdata[55:31] == '0)))
        else $error("capture location set without found flag");

endmodule

bind protobuf_field_locator_unit pbfl_checker u_pbfl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/protobuf_field_locator_unit_tb.sv =====
// self-checking testbench for the protobuf field locator unit
`timescale 1ns / 100ps

module protobuf_field_locator_unit_tb;
    import pbfl_pkg::*;

    // wire types the walker rejects
    localparam logic [2:0] WT_SGROUP = 3'd3;
    localparam logic [2:0] WT_EGROUP = 3'd4;
    localparam logic [2:0] WT_RSVD6  = 3'd6;
    localparam logic [2:0] WT_RSVD7  = 3'd7;

    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned PRINT_LIMIT    = 50;
    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned SETTLE_CYCLES  = 4;

    // one directed message: bytes sit in the low n bytes of msg, first byte highest
    typedef struct {
        int unsigned  n;
        logic [127:0] msg;
        bit           typed;
        pbfl_result_t want;
    } locator_case_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic                   cfg_addr    = CFG_FIRST;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    // data_byte
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   s_tlast     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    // decode_ok, error_kind, first_found, first_offset, first_length,
    // second_found, second_offset, second_length
    logic [OUT_TDATA_W-1:0] m_tdata;

    protobuf_field_locator_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // shared testbench state
    pbfl_result_t  pending_reports [$];
    logic [7:0]    msg_bytes [$];
    locator_case_t dir_cases [$];
    int unsigned   mismatch_count = 0;
    int unsigned   report_count   = 0;
    bit            idle_allowed   = 1'b1;
    bit            sender_gaps    = 1'b0;
    bit            long_hold_due  = 1'b0;

    // walker model state
    logic [31:0]   cap_field_first;
    logic [31:0]   cap_field_second;
    logic [1:0]    walk_phase;
    logic [34:0]   vint_acc;
    bit            vint_high;
    logic [3:0]    vint_count;
    logic [31:0]   tag_field_no;
    logic [12:0]   skip_left;
    logic [12:0]   msg_pos;
    logic [2:0]    sticky_err;
    pbfl_capture_t cap_first;
    pbfl_capture_t cap_second;

    function automatic void clear_walk();
        walk_phase   = PH_TAG;
        vint_acc     = '0;
        vint_high    = 1'b0;
        vint_count   = '0;
        tag_field_no = '0;
        skip_left    = '0;
        msg_pos      = '0;
        sticky_err   = ERR_NONE;
        cap_first    = '0;
        cap_second   = '0;
    endfunction

    // tag finished: pick the payload handling from the wire type
    function automatic void finish_tag();
        tag_field_no = vint_acc[34:3];
        case (vint_acc[2:0])
            WT_VARINT: walk_phase = PH_VALUE;
            WT_FIX64: begin
                walk_phase = PH_SKIP;
                skip_left  = 13'd8;
            end
            WT_LENDEL: walk_phase = PH_LENGTH;
            WT_FIX32: begin
                walk_phase = PH_SKIP;
                skip_left  = 13'd4;
            end
            default: sticky_err = ERR_WIRE;
        endcase
    endfunction

    // declared length finished: bound it, record a capture, then skip the payload
    function automatic void finish_length();
        logic [63:0] room;
        logic [12:0] len;
        room = 64'(MSG_LEN_MAX) - 64'(msg_pos);
        if (vint_high || 64'(vint_acc) > room) begin
            sticky_err = ERR_TRUNC;
        end else begin
            len = vint_acc[12:0];
            if (tag_field_no == cap_field_first) begin
                cap_first.found  = 1'b1;
                cap_first.offset = msg_pos[OFS_W-1:0];
                cap_first.length = len;
            end else if (tag_field_no == cap_field_second) begin
                cap_second.found  = 1'b1;
                cap_second.offset = msg_pos[OFS_W-1:0];
                cap_second.length = len;
            end
            if (len == 0) begin
                walk_phase = PH_TAG;
            end else begin
                walk_phase = PH_SKIP;
                skip_left  = len;
            end
        end
    endfunction

    // one byte into the walker while no error is pending
    function automatic void walk_byte(input logic [7:0] b);
        int unsigned k;
        k = 32'(vint_count);
        if (walk_phase == PH_SKIP) begin
            if (skip_left != 0)
                skip_left = skip_left - 13'd1;
            if (skip_left == 0)
                walk_phase = PH_TAG;
        end else begin
            if (k < 5)
                vint_acc = vint_acc | (35'(b[6:0]) << (7 * k));
            else if (k < 9) begin
                if (b[6:0] != 0)
                    vint_high = 1'b1;
            end else if (b[0])
                vint_high = 1'b1;

            if (b[7]) begin
                vint_count = vint_count + 4'd1;
                if (vint_count >= VCNT_LIMIT)
                    sticky_err = ERR_VARINT;
            end else begin
                if (walk_phase == PH_TAG)
                    finish_tag();
                else if (walk_phase == PH_LENGTH)
                    finish_length();
                else
                    walk_phase = PH_TAG;
                vint_acc   = '0;
                vint_high  = 1'b0;
                vint_count = '0;
            end
        end
    endfunction

    // accepted byte: returns 1 with the expected report on the last byte
    function automatic bit locate_step(input logic [7:0] b, input bit last,
                                       output pbfl_result_t rpt);
        rpt = '0;
        if (msg_pos >= 13'(MSG_LEN_MAX)) begin
            if (sticky_err == ERR_NONE)
                sticky_err = ERR_LONG;
        end else begin
            msg_pos = msg_pos + 13'd1;
            if (sticky_err == ERR_NONE)
                walk_byte(b);
        end
        if (!last)
            return 1'b0;
        if (sticky_err == ERR_NONE && (walk_phase != PH_TAG || vint_count != 0))
            sticky_err = ERR_TRUNC;
        rpt.decode_ok  = (sticky_err == ERR_NONE);
        rpt.error_kind = sticky_err;
        rpt.first      = cap_first;
        rpt.second     = cap_second;
        clear_walk();
        return 1'b1;
    endfunction

    function automatic pbfl_result_t outcome(input bit ok, input logic [2:0] err,
                                             input bit ff, input int unsigned fo,
                                             input int unsigned fl, input bit sf,
                                             input int unsigned so, input int unsigned sl);
        pbfl_result_t r;
        r.decode_ok     = ok;
        r.error_kind    = err;
        r.first.found   = ff;
        r.first.offset  = OFS_W'(fo);
        r.first.length  = LEN_W'(fl);
        r.second.found  = sf;
        r.second.offset = OFS_W'(so);
        r.second.length = LEN_W'(sl);
        return r;
    endfunction

    // varint with optional redundant continuation bytes, ten bytes at most
    function automatic void put_varint(input logic [63:0] value, input int unsigned pad);
        int unsigned need;
        int unsigned total;
        logic [63:0] rest;
        need = 1;
        rest = value >> 7;
        while (rest != 0) begin
            need++;
            rest = rest >> 7;
        end
        total = (need + pad > 10) ? 10 : need + pad;
        for (int unsigned i = 0; i < total; i++)
            msg_bytes.push_back({i != total - 1, 7'(value >> (7 * i))});
    endfunction

    function automatic int unsigned random_pad();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
    endfunction

    // mostly well-formed message with random fields, sometimes damaged
    function automatic void build_random_message();
        int unsigned nfields;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        logic [31:0] fld;
        logic [2:0]  wire_t;
        logic [63:0] tag;
        msg_bytes.delete();
        nfields = $urandom_range(1, 6);
        repeat (nfields) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                fld = cap_field_first;
            else if (pick < 5)
                fld = cap_field_second;
            else if (pick < 8)
                fld = $urandom_range(0, 15);
            else if (pick < 9)
                fld = $urandom;
            else
                fld = $urandom_range(0, 4095);

            pick = $urandom_range(0, 19);
            if (pick < 5)
                wire_t = WT_VARINT;
            else if (pick < 7)
                wire_t = WT_FIX64;
            else if (pick < 15)
                wire_t = WT_LENDEL;
            else if (pick < 17)
                wire_t = WT_FIX32;
            else begin
                case ($urandom_range(0, 3))
                    0: wire_t = WT_SGROUP;
                    1: wire_t = WT_EGROUP;
                    2: wire_t = WT_RSVD6;
                    default: wire_t = WT_RSVD7;
                endcase
            end

            // tag bits above bit 34 are dropped by the walker
            tag = {29'd0, fld, wire_t};
            if ($urandom_range(0, 15) == 0)
                tag[63:35] = 29'($urandom);
            put_varint(tag, random_pad());

            case (wire_t)
                WT_VARINT: put_varint({$urandom, $urandom} >> $urandom_range(0, 63),
                                      random_pad());
                WT_FIX64: repeat (8) msg_bytes.push_back(8'($urandom));
                WT_FIX32: repeat (4) msg_bytes.push_back(8'($urandom));
                WT_LENDEL: begin
                    if ($urandom_range(0, 24) == 0) begin
                        // oversized declared length, usually rejected at once
                        put_varint({$urandom, $urandom} >> $urandom_range(0, 52), 0);
                    end else begin
                        len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 300)
                                                           : $urandom_range(0, 12);
                        put_varint(64'(len), random_pad());
                        repeat (len) msg_bytes.push_back(8'($urandom));
                    end
                end
                default: ;
            endcase
        end

        // damage some messages
        case ($urandom_range(0, 11))
            0: begin
                cut = $urandom_range(1, msg_bytes.size());
                while (msg_bytes.size() > cut)
                    void'(msg_bytes.pop_back());
            end
            1: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom);
            2: repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
            3: begin
                repeat (10) msg_bytes.push_back(8'h80 | 8'($urandom));
                msg_bytes.push_back(8'h01);
            end
            default: ;
        endcase
    endfunction

    // offer one byte until it is taken, with an occasional gap before it
    task automatic send_byte(input logic [7:0] d, input bit last, input bit typed,
                             input pbfl_result_t want);
        pbfl_result_t predicted;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (locate_step(d, last, predicted))
            pending_reports.push_back(typed ? want : predicted);
    endtask

    task automatic send_message(input bit typed, input pbfl_result_t want);
        sender_gaps = idle_allowed && ($urandom_range(0, 3) != 0);
        for (int i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1, typed, want);
    endtask

    // stop offering and wait for every outstanding report
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_capture_fields(input logic [31:0] first_fld,
                                        input logic [31:0] second_fld);
        drain_reports();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_FIRST;
        cfg_wr_data <= first_fld;
        @(posedge aclk);
        cfg_addr    <= CFG_SECOND;
        cfg_wr_data <= second_fld;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cap_field_first  = first_fld;
        cap_field_second = second_fld;
    endtask

    task automatic run_random(input int unsigned byte_budget);
        int unsigned sent;
        sent = 0;
        while (sent < byte_budget) begin
            build_random_message();
            sent += msg_bytes.size();
            send_message(1'b0, '0);
        end
    endtask

    function automatic void load_directed_cases();
        // plain varint field, nothing captured
        dir_cases.push_back('{3, 128'h08_96_01, 1'b1, outcome(1, ERR_NONE, 0, 0, 0, 0, 0, 0)});
        // first capture field
        dir_cases.push_back('{5, 128'h12_03_41_42_43, 1'b1,
                              outcome(1, ERR_NONE, 1, 2, 3, 0, 0, 0)});
        // second capture field, empty payload
        dir_cases.push_back('{2, 128'h1A_00, 1'b1, outcome(1, ERR_NONE, 0, 0, 0, 1, 2, 0)});
        // later copy overwrites an earlier one
        dir_cases.push_back('{10, 128'h12_01_AA_12_02_BB_CC_1A_01_DD, 1'b1,
                              outcome(1, ERR_NONE, 1, 5, 2, 1, 9, 1)});
        // fixed 64-bit and 32-bit payloads
        dir_cases.push_back('{9, 128'h09_01_02_03_04_05_06_07_08, 1'b0, '0});
        dir_cases.push_back('{5, 128'h1D_FF_FF_FF_FF, 1'b0, '0});
        // rejected wire types
        dir_cases.push_back('{1, 128'h0B, 1'b1, outcome(0, ERR_WIRE, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{1, 128'h0C, 1'b1, outcome(0, ERR_WIRE, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{1, 128'h0E, 1'b1, outcome(0, ERR_WIRE, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{1, 128'h0F, 1'b1, outcome(0, ERR_WIRE, 0, 0, 0, 0, 0, 0)});
        // varint still continuing on its tenth byte
        dir_cases.push_back('{11, 128'hFF_FF_FF_FF_FF_FF_FF_FF_FF_FF_01, 1'b1,
                              outcome(0, ERR_VARINT, 0, 0, 0, 0, 0, 0)});
        // longest legal varint value
        dir_cases.push_back('{11, 128'h08_FF_FF_FF_FF_FF_FF_FF_FF_FF_01, 1'b1,
                              outcome(1, ERR_NONE, 0, 0, 0, 0, 0, 0)});
        // over-long tag whose upper bytes are ignored
        dir_cases.push_back('{8, 128'h92_80_80_80_80_01_01_AA, 1'b0, '0});
        dir_cases.push_back('{6, 128'h92_80_80_80_F0_01, 1'b0, '0});
        // declared length past the message limit, and with high bits set
        dir_cases.push_back('{3, 128'h12_FF_7F, 1'b1, outcome(0, ERR_TRUNC, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{7, 128'h12_80_80_80_80_80_01, 1'b1,
                              outcome(0, ERR_TRUNC, 0, 0, 0, 0, 0, 0)});
        // message ends inside a varint, a payload, or right after a tag
        dir_cases.push_back('{2, 128'h08_96, 1'b1, outcome(0, ERR_TRUNC, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{3, 128'h12_03_41, 1'b1, outcome(0, ERR_TRUNC, 1, 2, 3, 0, 0, 0)});
        dir_cases.push_back('{1, 128'h08, 1'b1, outcome(0, ERR_TRUNC, 0, 0, 0, 0, 0, 0)});
        dir_cases.push_back('{1, 128'h00, 1'b1, outcome(0, ERR_TRUNC, 0, 0, 0, 0, 0, 0)});
        // capture kept after a later error, nothing parsed after an error
        dir_cases.push_back('{4, 128'h1A_01_55_0B, 1'b1,
                              outcome(0, ERR_WIRE, 0, 0, 0, 1, 2, 1)});
        dir_cases.push_back('{4, 128'h0B_12_01_AA, 1'b1, outcome(0, ERR_WIRE, 0, 0, 0, 0, 0, 0)});
        // field number fifteen, empty payload
        dir_cases.push_back('{2, 128'h7A_00, 1'b0, '0});
    endfunction

    task automatic run_directed();
        for (int i = 0; i < dir_cases.size(); i++) begin
            msg_bytes.delete();
            for (int j = dir_cases[i].n - 1; j >= 0; j--)
                msg_bytes.push_back(dir_cases[i].msg[8 * j +: 8]);
            send_message(dir_cases[i].typed, dir_cases[i].want);
        end

        // full-size message ending in an empty capture whose offset wraps to zero
        msg_bytes.delete();
        msg_bytes.push_back(8'h0A);
        put_varint(64'(MSG_LEN_MAX - 5), 0);
        repeat (MSG_LEN_MAX - 5) msg_bytes.push_back(8'($urandom));
        msg_bytes.push_back(8'h12);
        msg_bytes.push_back(8'h00);
        send_message(1'b1, outcome(1, ERR_NONE, 1, 0, 0, 0, 0, 0));

        // message longer than the limit
        msg_bytes.delete();
        repeat (MSG_LEN_MAX + 4) msg_bytes.push_back(8'h00);
        send_message(1'b1, outcome(0, ERR_LONG, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at report %0d: %s got 0x%0h, expected 0x%0h",
                     report_count, what, got, want);
    endtask

    function automatic pbfl_result_t unpack_report(input logic [OUT_TDATA_W-1:0] t);
        pbfl_result_t r;
        r.decode_ok     = t[0];
        r.error_kind    = t[3:1];
        r.first.found   = t[4];
        r.first.offset  = t[16:5];
        r.first.length  = t[29:17];
        r.second.found  = t[30];
        r.second.offset = t[42:31];
        r.second.length = t[55:43];
        return r;
    endfunction

    task automatic check_report(input pbfl_result_t got);
        pbfl_result_t want;
        report_count++;
        if (pending_reports.size() == 0) begin
            report_mismatch("report with none pending", 64'(got), 64'(0));
        end else begin
            want = pending_reports.pop_front();
            if (got.decode_ok !== want.decode_ok)
                report_mismatch("decode_ok", 64'(got.decode_ok), 64'(want.decode_ok));
            if (got.error_kind !== want.error_kind)
                report_mismatch("error_kind", 64'(got.error_kind), 64'(want.error_kind));
            if (got.first.found !== want.first.found)
                report_mismatch("first_found", 64'(got.first.found),
                                64'(want.first.found));
            if (got.first.offset !== want.first.offset)
                report_mismatch("first_offset", 64'(got.first.offset),
                                64'(want.first.offset));
            if (got.first.length !== want.first.length)
                report_mismatch("first_length", 64'(got.first.length),
                                64'(want.first.length));
            if (got.second.found !== want.second.found)
                report_mismatch("second_found", 64'(got.second.found),
                                64'(want.second.found));
            if (got.second.offset !== want.second.offset)
                report_mismatch("second_offset", 64'(got.second.offset),
                                64'(want.second.offset));
            if (got.second.length !== want.second.length)
                report_mismatch("second_length", 64'(got.second.length),
                                64'(want.second.length));
        end
    endtask

    // result side: check each transfer, stall in random bursts and one long hold
    initial begin : result_sink
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned mode_left;
        bit          stalls_on;
        stall_left = 0;
        hold_left  = 0;
        mode_left  = 0;
        stalls_on  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_report(unpack_report(m_tdata));
            if (long_hold_due) begin
                long_hold_due = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                stalls_on = ($urandom_range(0, 2) != 0);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (idle_allowed && stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // main sequence
    initial begin : stimulus
        cap_field_first  = 32'd2;
        cap_field_second = 32'd3;
        clear_walk();
        load_directed_cases();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // capture fields as left by reset
        run_directed();
        run_random(400);

        // extreme field numbers, with the result side held off for a while
        write_capture_fields(32'd0, 32'hFFFF_FFFF);
        long_hold_due = 1'b1;
        run_random(400);

        // same field in both registers
        write_capture_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(350);

        write_capture_fields($urandom_range(4, 15), $urandom);
        run_random(350);

        // closing stretch without any idling
        drain_reports();
        idle_allowed = 1'b0;
        write_capture_fields(32'd1, 32'd2);
        run_random(400);

        drain_reports();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/pbfl_pkg.sv
rtl/core/pbfl_in_reg.sv
rtl/core/pbfl_walker.sv
rtl/core/pbfl_out_reg.sv
rtl/core/protobuf_field_locator_unit.sv
rtl/core/pbfl_checker.sv
dv/protobuf_field_locator_unit_tb.sv
